### rtl/transfer_credit_allocator_core_defines.svh
// Assertion macros for the transfer credit allocator.
`ifndef TRANSFER_CREDIT_ALLOCATOR_CORE_DEFINES_SVH
`define TRANSFER_CREDIT_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Checked outside reset.
`define TCA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define TCA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define TCA_ASSERT(label, prop, msg)
`define TCA_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

### rtl/tca_pkg.sv
// Types and constants shared by the transfer credit allocator.
`timescale 1ns / 1ps

package tca_pkg;

    // request type codes
    localparam logic [1:0] REQ_GRANT   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_END     = 2'd2;

    // requester kinds
    localparam logic [1:0] KIND_USER_RD = 2'd0;
    localparam logic [1:0] KIND_COLL_RD = 2'd1;
    localparam logic [1:0] KIND_USER_WR = 2'd2;
    localparam logic [1:0] KIND_COLL_WR = 2'd3;

    // active mask bits
    localparam logic [3:0] USER_RD_BIT = 4'h1;
    localparam logic [3:0] COLL_RD_BIT = 4'h2;
    localparam logic [3:0] WRITE_KINDS = 4'hC;

    // configuration register indexes
    localparam logic CFG_TRANSFER_LIMIT = 1'b0;
    localparam logic CFG_APPEND_LIMIT   = 1'b1;

    localparam logic [31:0] RESET_LIMIT = 32'd516096;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  requester_kind;
        logic [31:0] release_bytes;
    } t_req;

    typedef struct packed {
        logic        granted;
        logic [31:0] grant_bytes;
        logic [31:0] free_total_now;
        logic [31:0] free_append_now;
        logic [3:0]  active_kinds;
    } t_rsp;

    typedef struct packed {
        logic        reg_index;
        logic [31:0] wr_data;
    } t_cfg;

    typedef struct packed {
        logic [31:0] transfer_limit;
        logic [31:0] append_limit;
    } t_limits;

    typedef struct packed {
        logic [31:0] free_total;
        logic [31:0] free_append;
        logic [3:0]  active_mask;
    } t_state;

endpackage

### rtl/tca_chan_if.sv
// Valid/ready channel carrying one payload struct.
`timescale 1ns / 1ps

interface tca_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/tca_calc.sv
// Grant, release and end-of-use decision for one request.
`timescale 1ns / 1ps

module tca_calc (
    input  tca_pkg::t_req    i_req,
    input  tca_pkg::t_limits i_limits,
    input  tca_pkg::t_state  i_state,
    output tca_pkg::t_state  o_state,
    output tca_pkg::t_rsp    o_rsp
);

    logic        w_is_write;
    logic [3:0]  w_kind_bit;
    logic [3:0]  w_other_rd;
    logic        w_writes_active;
    logic        w_other_active;
    logic [31:0] w_rd_base;
    logic [31:0] w_rd_half;
    logic [31:0] w_rd_amt;
    logic [31:0] w_wr_half;
    logic [31:0] w_wr_cap;
    logic [31:0] w_wr_amt;
    logic [32:0] w_sum_total;
    logic [32:0] w_sum_append;
    logic [31:0] w_rel_total;
    logic [31:0] w_rel_append;
    logic        w_granted;
    logic [31:0] w_amount;

    assign w_is_write = (i_req.requester_kind == tca_pkg::KIND_USER_WR) ||
                        (i_req.requester_kind == tca_pkg::KIND_COLL_WR);
    assign w_kind_bit = 4'b0001 << i_req.requester_kind;
    assign w_other_rd = (i_req.requester_kind == tca_pkg::KIND_USER_RD) ?
                        tca_pkg::COLL_RD_BIT : tca_pkg::USER_RD_BIT;
    assign w_writes_active = |(i_state.active_mask & tca_pkg::WRITE_KINDS);
    assign w_other_active  = |(i_state.active_mask & w_other_rd);

    // read grant: transfer limit, less append limit under writes, halved when shared
    assign w_rd_base = !w_writes_active ? i_limits.transfer_limit :
                       (i_limits.transfer_limit > i_limits.append_limit) ?
                       (i_limits.transfer_limit - i_limits.append_limit) : 32'd0;
    assign w_rd_half = w_other_active ? (w_rd_base >> 1) : w_rd_base;
    assign w_rd_amt  = (i_state.free_total < w_rd_half) ? i_state.free_total : w_rd_half;

    // write grant: append limit, halved under writes, capped by both budgets
    assign w_wr_half = w_writes_active ? (i_limits.append_limit >> 1) : i_limits.append_limit;
    assign w_wr_cap  = (i_state.free_append < w_wr_half) ? i_state.free_append : w_wr_half;
    assign w_wr_amt  = (i_state.free_total < w_wr_cap) ? i_state.free_total : w_wr_cap;

    // release, saturating at the limits
    assign w_sum_total  = {1'b0, i_state.free_total} + {1'b0, i_req.release_bytes};
    assign w_sum_append = {1'b0, i_state.free_append} + {1'b0, i_req.release_bytes};
    assign w_rel_total  = (w_sum_total > {1'b0, i_limits.transfer_limit}) ?
                          i_limits.transfer_limit : w_sum_total[31:0];
    assign w_rel_append = (w_sum_append > {1'b0, i_limits.append_limit}) ?
                          i_limits.append_limit : w_sum_append[31:0];

    always_comb begin
        o_state   = i_state;
        w_granted = 1'b0;
        w_amount  = 32'd0;
        unique case (i_req.req_type)
            tca_pkg::REQ_GRANT: begin
                if (!w_is_write) begin
                    if (i_state.free_total != 32'd0) begin
                        w_granted            = 1'b1;
                        w_amount             = w_rd_amt;
                        o_state.free_total   = i_state.free_total - w_rd_amt;
                        o_state.active_mask  = i_state.active_mask | w_kind_bit;
                    end
                end else begin
                    if ((i_state.free_total != 32'd0) && (i_state.free_append != 32'd0)) begin
                        w_granted            = 1'b1;
                        w_amount             = w_wr_amt;
                        o_state.free_total   = i_state.free_total - w_wr_amt;
                        o_state.free_append  = i_state.free_append - w_wr_amt;
                        o_state.active_mask  = i_state.active_mask | w_kind_bit;
                    end
                end
            end
            tca_pkg::REQ_RELEASE: begin
                o_state.free_total = w_rel_total;
                if (w_is_write) begin
                    o_state.free_append = w_rel_append;
                end
            end
            tca_pkg::REQ_END: begin
                o_state.active_mask = i_state.active_mask & ~w_kind_bit;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

    assign o_rsp.granted         = w_granted;
    assign o_rsp.grant_bytes     = w_amount;
    assign o_rsp.free_total_now  = o_state.free_total;
    assign o_rsp.free_append_now = o_state.free_append;
    assign o_rsp.active_kinds    = o_state.active_mask;

endmodule

### rtl/transfer_credit_allocator_core.sv
// Top level of the transfer credit allocator: channels, budget state, pipeline registers.
// Path: a request is taken into the input register r_in, decided combinationally in tca_calc,
//   and its result is registered in r_rsp, which drives the response channel.
// Throughput: one request per cycle while o_rsp is not stalled; the budget state is updated
//   in the same cycle the decision is taken, so the next request sees it without a bubble.
// Reset (synchronous, active low): both limits and both budgets go to 516096 bytes,
//   the active mask clears, and both pipeline stages empty. Config is always ready.
`timescale 1ns / 1ps

`include "transfer_credit_allocator_core_defines.svh"

module transfer_credit_allocator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tca_chan_if.sink   i_req,
    tca_chan_if.source o_rsp,
    tca_chan_if.sink   i_cfg
);

    // input stage
    logic             r_in_valid;
    tca_pkg::t_req    r_in;

    // result stage
    logic             r_out_valid;
    tca_pkg::t_rsp    r_rsp;

    // limits and budgets
    tca_pkg::t_limits r_limits;
    tca_pkg::t_state  r_state;

    tca_pkg::t_state  w_next_state;
    tca_pkg::t_rsp    w_rsp;
    logic             w_advance;   // result stage can take a new result
    logic             w_fire;      // decision taken on the request in the input stage
    logic             w_in_accept;
    logic             w_cfg_accept;

    assign w_advance    = !r_out_valid || o_rsp.ready;
    assign w_fire       = r_in_valid && w_advance;
    assign i_req.ready  = !r_in_valid || w_advance;
    assign w_in_accept  = i_req.valid && i_req.ready;

    assign i_cfg.ready  = 1'b1;
    assign w_cfg_accept = i_cfg.valid;

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

    // all the per-request work happens here, between r_in and r_rsp
    tca_calc u_calc (
        .i_req    (r_in),
        .i_limits (r_limits),
        .i_state  (r_state),
        .o_state  (w_next_state),
        .o_rsp    (w_rsp)
    );

    // input register: holds while the result stage is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in <= i_req.payload;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_rsp <= w_rsp;
        end
    end

    // Limits and budgets. A limit write reloads its budget and takes priority here; the user must
    // send config only while no request is in flight, as the block itself does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.transfer_limit <= tca_pkg::RESET_LIMIT;
            r_limits.append_limit   <= tca_pkg::RESET_LIMIT;
            r_state.free_total      <= tca_pkg::RESET_LIMIT;
            r_state.free_append     <= tca_pkg::RESET_LIMIT;
            r_state.active_mask     <= 4'd0;
        end else if (w_cfg_accept) begin
            unique case (i_cfg.payload.reg_index)
                tca_pkg::CFG_TRANSFER_LIMIT: begin
                    r_limits.transfer_limit <= i_cfg.payload.wr_data;
                    r_state.free_total      <= i_cfg.payload.wr_data;
                end
                tca_pkg::CFG_APPEND_LIMIT: begin
                    r_limits.append_limit <= i_cfg.payload.wr_data;
                    r_state.free_append   <= i_cfg.payload.wr_data;
                end
            endcase
        end else if (w_fire) begin
            r_state <= w_next_state;
        end
    end

    // Budgets never climb above their limits: grants only subtract,
    // releases saturate and limit writes reload.
    `TCA_ASSERT(a_total_within_limit, r_state.free_total <= r_limits.transfer_limit, "free total budget above transfer limit")
    `TCA_ASSERT(a_append_within_limit, r_state.free_append <= r_limits.append_limit, "free append budget above append limit")
    `TCA_ASSERT(a_no_bytes_without_grant, (r_out_valid && !r_rsp.granted) |-> (r_rsp.grant_bytes == 32'd0), "bytes reported without a grant")
    `TCA_ASSERT(a_grant_marks_active, (w_fire && w_rsp.granted && !w_cfg_accept) |=> r_state.active_mask[$past(r_in.requester_kind)], "granted kind not marked active")
    `TCA_ASSERT(a_reset_empties_pipe, !$past(i_rst_n) |-> (!r_in_valid && !r_out_valid), "pipeline not empty after reset")

endmodule
